[rtl/elp_pkg.sv]
// ----------------------------------------------------------------------------
// elp_pkg
// Types and constants shared by the edge list parser front, queue and back.
// ----------------------------------------------------------------------------
package elp_pkg;

    localparam logic [7:0] CHR_HASH    = 8'h23;
    localparam logic [7:0] CHR_PERCENT = 8'h25;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_COMMA   = 8'h2C;
    localparam logic [7:0] CHR_SPACE   = 8'h20;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_ZERO    = 8'h30;
    localparam logic [7:0] CHR_NINE    = 8'h39;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_INVALID   = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    typedef enum logic [2:0] {
        CLS_DIGIT   = 3'd0,
        CLS_SEP     = 3'd1,
        CLS_CR      = 3'd2,
        CLS_LF      = 3'd3,
        CLS_COMMENT = 3'd4,
        CLS_OTHER   = 3'd5
    } t_byte_class;

    typedef enum logic [2:0] {
        MODE_LINE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_FIRST   = 3'd2,
        MODE_SEP     = 3'd3,
        MODE_SECOND  = 3'd4,
        MODE_ERROR   = 3'd5
    } t_mode;

    typedef struct packed {
        t_byte_class cls;
        logic [3:0]  digit;
        logic        last;
    } t_class_item;

endpackage

[rtl/elp_front.sv]
// ----------------------------------------------------------------------------
// elp_front
// Classifies each incoming text byte and extracts its digit value.
// ----------------------------------------------------------------------------
module elp_front
    import elp_pkg::*;
(
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    output t_class_item o_item
);

    t_byte_class w_cls;

    always_comb begin
        priority if (i_text_byte >= CHR_ZERO && i_text_byte <= CHR_NINE) begin
            w_cls = CLS_DIGIT;
        end else if (i_text_byte == CHR_TAB || i_text_byte == CHR_COMMA ||
                     i_text_byte == CHR_SPACE) begin
            w_cls = CLS_SEP;
        end else if (i_text_byte == CHR_CR) begin
            w_cls = CLS_CR;
        end else if (i_text_byte == CHR_LF) begin
            w_cls = CLS_LF;
        end else if (i_text_byte == CHR_HASH || i_text_byte == CHR_PERCENT) begin
            w_cls = CLS_COMMENT;
        end else begin
            w_cls = CLS_OTHER;
        end
    end

    // ascii digits keep their value in the low nibble
    assign o_item.cls   = w_cls;
    assign o_item.digit = i_text_byte[3:0];
    assign o_item.last  = i_end_of_text;

endmodule

[rtl/elp_queue.sv]
// ----------------------------------------------------------------------------
// elp_queue
// Two-entry queue of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module elp_queue
    import elp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push_valid,
    input  t_class_item i_item,
    output logic        o_full,
    output logic        o_valid,
    output t_class_item o_item,
    input  logic        i_pop
);

    t_class_item r_slot [2];
    logic [1:0]  r_count, n_count;
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic        w_push;
    logic        w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_slot[r_rd_ptr];
    assign w_push  = i_push_valid && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 2'd1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 2'd0;
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("queue count beyond depth");

    a_push_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count missed a push");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with count");
`endif

endmodule

[rtl/elp_back.sv]
// ----------------------------------------------------------------------------
// elp_back
// Line parser state machine, decimal accumulator and registered result beat.
// ----------------------------------------------------------------------------
module elp_back
    import elp_pkg::*;
#(
    parameter int ID_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  t_class_item        i_q_item,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_edge_valid,
    output logic [ID_BITS-1:0] o_source_id,
    output logic [ID_BITS-1:0] o_target_id,
    output logic [1:0]         o_error_code
);

    localparam int SUM_BITS = ID_BITS + 4;

    t_mode              r_mode, n_mode;
    logic [ID_BITS-1:0] r_acc, n_acc;
    logic [ID_BITS-1:0] r_held, n_held;

    logic               r_out_valid;
    logic               r_edge_valid;
    logic [ID_BITS-1:0] r_src;
    logic [ID_BITS-1:0] r_tgt;
    logic [1:0]         r_err;

    logic               w_take;
    logic               w_is_digit;
    logic [ID_BITS-1:0] w_base;
    logic [SUM_BITS-1:0] w_base_x;
    logic [SUM_BITS-1:0] w_sum;
    logic               w_ovf;
    logic               w_line_start;
    logic               w_res_valid;
    logic               w_edge;
    logic [ID_BITS-1:0] w_src;
    logic [ID_BITS-1:0] w_tgt;
    logic [1:0]         w_err;

    assign w_take     = i_q_valid && (!r_out_valid || !i_stall);
    assign o_q_pop    = w_take;
    assign w_is_digit = (i_q_item.cls == CLS_DIGIT);

    // a digit continues the id only inside the first or second id
    assign w_base   = (w_is_digit && (r_mode == MODE_FIRST || r_mode == MODE_SECOND))
                      ? r_acc : '0;
    assign w_base_x = {4'b0, w_base};
    assign w_sum    = (w_base_x << 3) + (w_base_x << 1) + SUM_BITS'(i_q_item.digit);
    assign w_ovf    = |w_sum[SUM_BITS-1:ID_BITS];

    always_comb begin
        n_mode       = r_mode;
        n_acc        = r_acc;
        n_held       = r_held;
        w_line_start = 1'b0;
        w_edge       = 1'b0;
        w_src        = '0;
        w_tgt        = '0;
        w_err        = ERR_NONE;

        unique case (r_mode)
            MODE_COMMENT: begin
                if (i_q_item.cls == CLS_LF) begin
                    n_mode = MODE_LINE;
                end
            end
            MODE_FIRST: begin
                if (w_is_digit) begin
                    if (w_ovf) begin
                        w_err = ERR_TOO_LARGE;
                    end else begin
                        n_acc = w_sum[ID_BITS-1:0];
                    end
                end else begin
                    n_held = r_acc;
                    n_acc  = '0;
                    if (i_q_item.cls == CLS_SEP) begin
                        n_mode = MODE_SEP;
                    end else begin
                        w_err = ERR_INVALID;
                    end
                end
            end
            MODE_SEP: begin
                if (w_is_digit) begin
                    n_mode = MODE_SECOND;
                    if (w_ovf) begin
                        w_err = ERR_TOO_LARGE;
                    end else begin
                        n_acc = w_sum[ID_BITS-1:0];
                    end
                end else if (i_q_item.cls != CLS_SEP) begin
                    w_err = ERR_INVALID;
                end
            end
            MODE_SECOND: begin
                if (w_is_digit) begin
                    if (w_ovf) begin
                        w_err = ERR_TOO_LARGE;
                    end else begin
                        n_acc = w_sum[ID_BITS-1:0];
                    end
                end else begin
                    w_edge       = 1'b1;
                    w_src        = r_held;
                    w_tgt        = r_acc;
                    n_acc        = '0;
                    n_mode       = MODE_LINE;
                    w_line_start = 1'b1;
                end
            end
            MODE_ERROR: begin
            end
            default: begin
                w_line_start = 1'b1;
            end
        endcase

        // the terminating byte of the second id is reparsed as at line start
        if (w_line_start) begin
            unique case (i_q_item.cls)
                CLS_CR, CLS_LF: begin
                    n_mode = MODE_LINE;
                end
                CLS_COMMENT: begin
                    n_mode = MODE_COMMENT;
                end
                CLS_DIGIT: begin
                    n_mode = MODE_FIRST;
                    if (w_ovf) begin
                        w_err = ERR_TOO_LARGE;
                    end else begin
                        n_acc = w_sum[ID_BITS-1:0];
                    end
                end
                default: begin
                    w_err = ERR_INVALID;
                end
            endcase
        end

        if (w_err != ERR_NONE) begin
            n_mode = MODE_ERROR;
        end

        if (i_q_item.last) begin
            if (n_mode == MODE_FIRST || n_mode == MODE_SEP) begin
                w_err = ERR_INVALID;
            end else if (n_mode == MODE_SECOND) begin
                w_edge = 1'b1;
                w_src  = n_held;
                w_tgt  = n_acc;
            end
            n_mode = MODE_LINE;
            n_acc  = '0;
            n_held = '0;
        end

        w_res_valid = w_edge || (w_err != ERR_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_LINE;
            r_acc       <= '0;
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_take) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                r_held <= n_held;
            end
            if (w_take) begin
                r_out_valid <= w_res_valid;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && w_res_valid) begin
            r_edge_valid <= w_edge;
            r_src        <= w_src;
            r_tgt        <= w_tgt;
            r_err        <= w_err;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_edge_valid = r_edge_valid;
    assign o_source_id  = r_src;
    assign o_target_id  = r_tgt;
    assign o_error_code = r_err;

`ifndef NO_ASSERTIONS
    a_last_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_q_item.last) |=> (r_mode == MODE_LINE && r_acc == '0 && r_held == '0))
        else $error("parser not back at line start after end of text");

    a_beat_has_content: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_edge_valid) |-> (r_err != ERR_NONE && r_src == '0 && r_tgt == '0))
        else $error("result beat without edge carries no error or stale ids");

    a_idle_acc_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_LINE || r_mode == MODE_COMMENT) |-> r_acc == '0)
        else $error("accumulator not cleared between lines");
`endif

endmodule

[rtl/edge_list_text_parser_top.sv]
// ----------------------------------------------------------------------------
// edge_list_text_parser_top
// Text edge list parser: bytes in, (source, target) vertex id pairs out.
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall with i_text_byte and i_end_of_text, one
//   byte per beat; o_stall rises only when the two-entry byte queue is full
//   output channel: o_valid / i_stall with o_edge_valid, o_source_id,
//   o_target_id and o_error_code; a beat goes out only for an edge, an
//   error, or both
//   throughput is one byte per cycle while the receiver does not stall; the
//   back-end parser accumulates by shift-add (times ten plus digit)
//   each accepted byte waits in a queue slot, is parsed, and its beat is
//   offered from the output register
//   when the receiver stalls the output register holds its beat and the
//   parser waits, so the queue fills with two bytes and o_stall rises
//   reset (synchronous, active low) empties the queue and the output register
//   and puts the parser at line start with cleared ids; after an error bytes
//   are dropped up to and including the next end_of_text byte
// ----------------------------------------------------------------------------
module edge_list_text_parser_top
    import elp_pkg::*;
#(
    parameter int ID_BITS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_text_byte,
    input  logic               i_end_of_text,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_edge_valid,
    output logic [ID_BITS-1:0] o_source_id,
    output logic [ID_BITS-1:0] o_target_id,
    output logic [1:0]         o_error_code
);

    t_class_item w_front_item;
    t_class_item w_q_item;
    logic        w_q_valid;
    logic        w_q_pop;

    elp_front u_front (
        .i_text_byte   (i_text_byte),
        .i_end_of_text (i_end_of_text),
        .o_item        (w_front_item)
    );

    elp_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (i_valid),
        .i_item       (w_front_item),
        .o_full       (o_stall),
        .o_valid      (w_q_valid),
        .o_item       (w_q_item),
        .i_pop        (w_q_pop)
    );

    elp_back #(
        .ID_BITS (ID_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (w_q_valid),
        .i_q_item     (w_q_item),
        .o_q_pop      (w_q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_edge_valid (o_edge_valid),
        .o_source_id  (o_source_id),
        .o_target_id  (o_target_id),
        .o_error_code (o_error_code)
    );

endmodule
